// File: hw/rtl/nrsp_pkg.sv
// Package for the NDEF record stream parser.
// Holds the phase encoding, byte class and status codes, and the state and result structs.
// No dependencies.
package nrsp_pkg;

    localparam logic [7:0] TAG_NDEF_MSG = 8'h03;
    localparam logic [7:0] LEN_ESCAPE   = 8'hFF;
    localparam logic [7:0] HDR_SR_MASK  = 8'h10;
    localparam logic [7:0] HDR_IL_MASK  = 8'h08;
    localparam logic [31:0] LONG_PLEN_BYTES = 32'd4;

    localparam logic [2:0] CLS_FRAME   = 3'd0;
    localparam logic [2:0] CLS_TYPE    = 3'd1;
    localparam logic [2:0] CLS_ID      = 3'd2;
    localparam logic [2:0] CLS_PAYLOAD = 3'd3;
    localparam logic [2:0] CLS_TRAIL   = 3'd4;
    localparam logic [2:0] CLS_REJECT  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_TAG   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_OVERRUN   = 2'd3;

    typedef enum logic [3:0] {
        PH_TAG   = 4'd0,
        PH_LEN   = 4'd1,
        PH_LHI   = 4'd2,
        PH_LLO   = 4'd3,
        PH_HDR   = 4'd4,
        PH_TLEN  = 4'd5,
        PH_PLEN  = 4'd6,
        PH_IDLEN = 4'd7,
        PH_TYPE  = 4'd8,
        PH_ID    = 4'd9,
        PH_PAY   = 4'd10,
        PH_TRAIL = 4'd11,
        PH_DRAIN = 4'd12
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] record_remaining;
        logic [1:0]  header_flags;
        logic [7:0]  type_len;
        logic [31:0] payload_len;
        logic [7:0]  id_len;
        logic [31:0] field_count;
        logic [1:0]  error_latch;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  data_out;
        logic [7:0]  rec_type_len;
        logic [31:0] rec_payload_len;
        logic        record_complete;
        logic [1:0]  status;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:            PH_TAG,
        record_remaining: 16'd0,
        header_flags:     2'd0,
        type_len:         8'd0,
        payload_len:      32'd0,
        id_len:           8'd0,
        field_count:      32'd0,
        error_latch:      2'd0
    };

endpackage

// File: hw/rtl/nrsp_in_if.sv
// Input channel of the NDEF record stream parser: one captured tag byte per item.
// No dependencies.
interface nrsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

// File: hw/rtl/nrsp_out_if.sv
// Output channel of the NDEF record stream parser: one classified byte per item.
// No dependencies.
interface nrsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_class;
    logic [7:0]  data_out;
    logic [7:0]  rec_type_len;
    logic [31:0] rec_payload_len;
    logic        record_complete;
    logic [1:0]  status;

    modport source (output valid, output byte_class, output data_out, output rec_type_len,
                    output rec_payload_len, output record_complete, output status,
                    input ready);
    modport sink (input valid, input byte_class, input data_out, input rec_type_len,
                  input rec_payload_len, input record_complete, input status,
                  output ready);
endinterface

// File: hw/rtl/ndef_record_stream_parser_core.sv
// Top level of the NDEF record stream parser.
// Depends on nrsp_pkg, nrsp_in_if, nrsp_out_if and nrsp_step.
//
// The parser takes one captured tag byte per item and returns one classified byte per item,
// in order. It accepts a new item every cycle while the output is not stalled; a byte is
// held in the input register, and the combinational parse step loads its result into the
// result register when the byte advances. The sustained rate of one item per cycle is set by
// the parse state, which is updated once per byte. Backpressure on the output stalls
// the input register and then the input.
// An item marked end_of_data returns the parser to expecting a new message tag.
module ndef_record_stream_parser_core
    import nrsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    nrsp_in_if.sink    ingress,
    nrsp_out_if.source egress
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_eod_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_reg;
    result_t      result;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         advance;
    logic         in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || egress.ready);
    assign ingress.ready = !in_valid_reg || advance;
    assign in_take       = ingress.valid && ingress.ready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (egress.ready ? 1'b0 : out_valid_reg);

    nrsp_step u_step (
        .state       (state_reg),
        .data_byte   (in_byte_reg),
        .end_of_data (in_eod_reg),
        .state_next  (state_next),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= ingress.data_byte;
            in_eod_reg  <= ingress.end_of_data;
        end
        if (advance)
            out_reg <= result;
    end

    assign egress.valid           = out_valid_reg;
    assign egress.byte_class      = out_reg.byte_class;
    assign egress.data_out        = out_reg.data_out;
    assign egress.rec_type_len    = out_reg.rec_type_len;
    assign egress.rec_payload_len = out_reg.rec_payload_len;
    assign egress.record_complete = out_reg.record_complete;
    assign egress.status          = out_reg.status;

    a_eod_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_eod_reg |=> state_reg.phase == PH_TAG)
        else $error("Parser state did not return to the tag phase after an end mark.");

    a_complete_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.record_complete |-> out_reg.status == ST_OK)
        else $error("Record completed on a byte that also reports an error.");

    a_reject_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.byte_class == CLS_REJECT) == (out_reg.status != ST_OK)))
        else $error("Rejected class and error status disagree.");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_eod_reg))
        else $error("Input register changed while its item was stalled.");

endmodule

// File: hw/rtl/nrsp_step.sv
// Combinational parse step: next parser state and the result for one byte.
// Depends on nrsp_pkg.
module nrsp_step
    import nrsp_pkg::*;
(
    input  parse_state_t state,
    input  logic [7:0]   data_byte,
    input  logic         end_of_data,
    output parse_state_t state_next,
    output result_t      result
);

    typedef enum logic [1:0] {
        SEC_TYPE = 2'd0,
        SEC_ID   = 2'd1,
        SEC_PAY  = 2'd2
    } section_t;

    function automatic phase_t first_section(section_t from, logic [7:0] tl, logic [7:0] il,
                                             logic [31:0] pl);
        phase_t ph;
        if (from == SEC_TYPE && tl != 8'd0)
            ph = PH_TYPE;
        else if ((from == SEC_TYPE || from == SEC_ID) && il != 8'd0)
            ph = PH_ID;
        else if (pl != 32'd0)
            ph = PH_PAY;
        else
            ph = PH_TRAIL;
        return ph;
    endfunction

    parse_state_t n;
    logic [2:0]   cls;
    logic [1:0]   st;
    logic         done;
    logic         pl_known;
    logic         in_record;
    logic [31:0]  fc_inc;
    logic [31:0]  plen_shift;
    logic [15:0]  rem_llo;

    assign in_record  = (state.phase >= PH_HDR) && (state.phase <= PH_PAY);
    assign fc_inc     = state.field_count + 32'd1;
    assign plen_shift = {state.payload_len[23:0], data_byte};
    assign rem_llo    = state.record_remaining | {8'd0, data_byte};

    always_comb
    begin
        n        = state;
        cls      = CLS_FRAME;
        st       = ST_OK;
        done     = 1'b0;
        pl_known = (state.phase >= PH_IDLEN) && (state.phase <= PH_TRAIL);

        if (in_record && state.record_remaining != 16'd0)
            n.record_remaining = state.record_remaining - 16'd1;

        unique case (state.phase)
            PH_TAG:
            begin
                if (data_byte == TAG_NDEF_MSG)
                    n.phase = PH_LEN;
                else
                    st = ST_BAD_TAG;
            end
            PH_LEN:
            begin
                if (data_byte == LEN_ESCAPE)
                    n.phase = PH_LHI;
                else
                begin
                    n.record_remaining = {8'd0, data_byte};
                    n.phase = (data_byte != 8'd0) ? PH_HDR : PH_TRAIL;
                end
            end
            PH_LHI:
            begin
                n.record_remaining = {data_byte, 8'd0};
                n.phase = PH_LLO;
            end
            PH_LLO:
            begin
                n.record_remaining = rem_llo;
                n.phase = (rem_llo != 16'd0) ? PH_HDR : PH_TRAIL;
            end
            PH_HDR:
            begin
                n.header_flags = {(data_byte & HDR_SR_MASK) != 8'd0,
                                  (data_byte & HDR_IL_MASK) != 8'd0};
                n.phase = PH_TLEN;
            end
            PH_TLEN:
            begin
                n.type_len    = data_byte;
                n.payload_len = 32'd0;
                n.field_count = 32'd0;
                n.phase       = PH_PLEN;
            end
            PH_PLEN:
            begin
                n.payload_len = plen_shift;
                n.field_count = fc_inc;
                if (state.header_flags[1] || fc_inc >= LONG_PLEN_BYTES)
                begin
                    pl_known      = 1'b1;
                    n.field_count = 32'd0;
                    if (state.header_flags[0])
                        n.phase = PH_IDLEN;
                    else
                    begin
                        n.phase = first_section(SEC_TYPE, state.type_len, state.id_len,
                                                plen_shift);
                        done = (n.phase == PH_TRAIL);
                    end
                end
            end
            PH_IDLEN:
            begin
                n.id_len      = data_byte;
                n.field_count = 32'd0;
                n.phase = first_section(SEC_TYPE, state.type_len, data_byte,
                                        state.payload_len);
                done = (n.phase == PH_TRAIL);
            end
            PH_TYPE:
            begin
                cls = CLS_TYPE;
                n.field_count = fc_inc;
                if (fc_inc >= {24'd0, state.type_len})
                begin
                    n.field_count = 32'd0;
                    n.phase = first_section(SEC_ID, state.type_len, state.id_len,
                                            state.payload_len);
                    done = (n.phase == PH_TRAIL);
                end
            end
            PH_ID:
            begin
                cls = CLS_ID;
                n.field_count = fc_inc;
                if (fc_inc >= {24'd0, state.id_len})
                begin
                    n.field_count = 32'd0;
                    n.phase = first_section(SEC_PAY, state.type_len, state.id_len,
                                            state.payload_len);
                    done = (n.phase == PH_TRAIL);
                end
            end
            PH_PAY:
            begin
                cls = CLS_PAYLOAD;
                n.field_count = fc_inc;
                if (fc_inc >= state.payload_len)
                begin
                    n.field_count = 32'd0;
                    n.phase = PH_TRAIL;
                    done = 1'b1;
                end
            end
            PH_TRAIL:
            begin
                cls = CLS_TRAIL;
            end
            default:
            begin
                cls = CLS_REJECT;
                st  = state.error_latch;
            end
        endcase

        if (state.phase < PH_TRAIL)
        begin
            if (st == ST_OK && in_record && !done && n.record_remaining == 16'd0)
                st = ST_OVERRUN;
            if (st == ST_OK && end_of_data && n.phase != PH_TRAIL)
                st = ST_TRUNCATED;
            if (st != ST_OK)
            begin
                cls           = CLS_REJECT;
                n.error_latch = st;
                n.phase       = PH_DRAIN;
            end
        end

        result.byte_class      = cls;
        result.data_out        = data_byte;
        result.rec_type_len    = n.type_len;
        result.rec_payload_len = pl_known ? n.payload_len : 32'd0;
        result.record_complete = done;
        result.status          = st;

        state_next = end_of_data ? STATE_RESET : n;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for ndef_record_stream_parser_core: NDEF TLV byte streams in,
// classified bytes out, each compared with an in-line parser model.
// Depends on nrsp_pkg, nrsp_in_if, nrsp_out_if and the parser RTL.
module testbench;
    import nrsp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [7:0] data;
        logic       eod;
    } tag_byte_t;

    logic clk;
    logic rst_n;

    nrsp_in_if  byte_in ();
    nrsp_out_if byte_out ();

    ndef_record_stream_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .ingress(byte_in),
        .egress (byte_out)
    );

    tag_byte_t    capture_stream[$];
    result_t      predicted_bytes[$];
    logic [7:0]   record_bytes[$];
    logic [7:0]   msg[$];
    parse_state_t tracker;
    tag_byte_t    drive_item;
    result_t      oldest;
    logic         byte_taken;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           items_queued;
    int           items_accepted;
    int           mismatches;
    int           cycle_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic open_section(input int from);
        tracker.field_count = 32'd0;
        if (from == 0 && tracker.type_len != 8'd0)
        begin
            tracker.phase = PH_TYPE;
            return 1'b0;
        end
        if (from <= 1 && tracker.id_len != 8'd0)
        begin
            tracker.phase = PH_ID;
            return 1'b0;
        end
        if (tracker.payload_len != 32'd0)
        begin
            tracker.phase = PH_PAY;
            return 1'b0;
        end
        tracker.phase = PH_TRAIL;
        return 1'b1;
    endfunction

    function automatic result_t parse_tag_byte(input logic [7:0] b, input logic eod);
        phase_t     entry;
        logic [2:0] cls;
        logic [1:0] code;
        logic       done;
        logic       pl_known;
        logic       in_record;
        result_t    r;
        entry = tracker.phase;
        cls = CLS_FRAME;
        code = ST_OK;
        done = 1'b0;
        pl_known = (entry >= PH_IDLEN) && (entry <= PH_TRAIL);
        in_record = (entry >= PH_HDR) && (entry <= PH_PAY);
        if (in_record && tracker.record_remaining != 16'd0)
            tracker.record_remaining = tracker.record_remaining - 16'd1;
        case (entry)
            PH_TAG:
            begin
                if (b == TAG_NDEF_MSG)
                    tracker.phase = PH_LEN;
                else
                    code = ST_BAD_TAG;
            end
            PH_LEN:
            begin
                if (b == LEN_ESCAPE)
                    tracker.phase = PH_LHI;
                else
                begin
                    tracker.record_remaining = {8'd0, b};
                    tracker.phase = (b != 8'd0) ? PH_HDR : PH_TRAIL;
                end
            end
            PH_LHI:
            begin
                tracker.record_remaining = {b, 8'd0};
                tracker.phase = PH_LLO;
            end
            PH_LLO:
            begin
                tracker.record_remaining = tracker.record_remaining | {8'd0, b};
                tracker.phase = (tracker.record_remaining != 16'd0) ? PH_HDR : PH_TRAIL;
            end
            PH_HDR:
            begin
                tracker.header_flags = {(b & HDR_SR_MASK) != 8'd0, (b & HDR_IL_MASK) != 8'd0};
                tracker.phase = PH_TLEN;
            end
            PH_TLEN:
            begin
                tracker.type_len = b;
                tracker.payload_len = 32'd0;
                tracker.field_count = 32'd0;
                tracker.phase = PH_PLEN;
            end
            PH_PLEN:
            begin
                tracker.payload_len = {tracker.payload_len[23:0], b};
                tracker.field_count = tracker.field_count + 32'd1;
                if (tracker.header_flags[1] || tracker.field_count >= LONG_PLEN_BYTES)
                begin
                    pl_known = 1'b1;
                    tracker.field_count = 32'd0;
                    if (tracker.header_flags[0])
                        tracker.phase = PH_IDLEN;
                    else
                        done = open_section(0);
                end
            end
            PH_IDLEN:
            begin
                tracker.id_len = b;
                done = open_section(0);
            end
            PH_TYPE:
            begin
                cls = CLS_TYPE;
                tracker.field_count = tracker.field_count + 32'd1;
                if (tracker.field_count >= {24'd0, tracker.type_len})
                    done = open_section(1);
            end
            PH_ID:
            begin
                cls = CLS_ID;
                tracker.field_count = tracker.field_count + 32'd1;
                if (tracker.field_count >= {24'd0, tracker.id_len})
                    done = open_section(2);
            end
            PH_PAY:
            begin
                cls = CLS_PAYLOAD;
                tracker.field_count = tracker.field_count + 32'd1;
                if (tracker.field_count >= tracker.payload_len)
                begin
                    tracker.field_count = 32'd0;
                    tracker.phase = PH_TRAIL;
                    done = 1'b1;
                end
            end
            PH_TRAIL:
                cls = CLS_TRAIL;
            default:
            begin
                cls = CLS_REJECT;
                code = tracker.error_latch;
            end
        endcase
        if (entry < PH_TRAIL)
        begin
            if (code == ST_OK && in_record && !done && tracker.record_remaining == 16'd0)
                code = ST_OVERRUN;
            if (code == ST_OK && eod && tracker.phase != PH_TRAIL)
                code = ST_TRUNCATED;
            if (code != ST_OK)
            begin
                cls = CLS_REJECT;
                tracker.error_latch = code;
                tracker.phase = PH_DRAIN;
            end
        end
        r.byte_class = cls;
        r.data_out = b;
        r.rec_type_len = tracker.type_len;
        r.rec_payload_len = pl_known ? tracker.payload_len : 32'd0;
        r.record_complete = done;
        r.status = code;
        if (eod)
            tracker = STATE_RESET;
        return r;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_out.valid && byte_out.ready)
            begin
                if (predicted_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected item, expected none, got data_out %0h",
                                 $time, byte_out.data_out);
                end
                else
                begin
                    oldest = predicted_bytes.pop_front();
                    report_field("byte_class", 32'(oldest.byte_class),
                                 32'(byte_out.byte_class));
                    report_field("data_out", 32'(oldest.data_out), 32'(byte_out.data_out));
                    report_field("rec_type_len", 32'(oldest.rec_type_len),
                                 32'(byte_out.rec_type_len));
                    report_field("rec_payload_len", oldest.rec_payload_len,
                                 byte_out.rec_payload_len);
                    report_field("record_complete", 32'(oldest.record_complete),
                                 32'(byte_out.record_complete));
                    report_field("status", 32'(oldest.status), 32'(byte_out.status));
                end
            end
            if (byte_in.valid && byte_in.ready)
            begin
                predicted_bytes.push_back(parse_tag_byte(byte_in.data_byte,
                                                         byte_in.end_of_data));
                items_accepted++;
            end
            byte_taken <= byte_in.valid && byte_in.ready;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!byte_in.valid || byte_taken)
            begin
                if (capture_stream.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drive_item = capture_stream.pop_front();
                    byte_in.valid <= 1'b1;
                    byte_in.data_byte <= drive_item.data;
                    byte_in.end_of_data <= drive_item.eod;
                end
                else
                    byte_in.valid <= 1'b0;
            end
            byte_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("** ndef_record_stream_parser_core: FAILED **");
            $finish;
        end
    end

    task automatic queue_message(input int cut);
        int last;
        last = (cut >= 0) ? cut : msg.size() - 1;
        for (int i = 0; i <= last; i++)
        begin
            capture_stream.push_back(tag_byte_t'{data: msg[i], eod: (i == last)});
            items_queued++;
        end
    endtask

    task automatic build_record(input bit sr, input bit il, input int type_n, input int id_n,
                                input logic [31:0] plen_val, input int pay_n);
        logic [7:0] hdr;
        hdr = 8'($urandom);
        hdr = sr ? (hdr | HDR_SR_MASK) : (hdr & ~HDR_SR_MASK);
        hdr = il ? (hdr | HDR_IL_MASK) : (hdr & ~HDR_IL_MASK);
        record_bytes = {hdr, 8'(type_n)};
        if (sr)
            record_bytes.push_back(plen_val[7:0]);
        else
            for (int k = 3; k >= 0; k--)
                record_bytes.push_back(plen_val[8*k +: 8]);
        if (il)
            record_bytes.push_back(8'(id_n));
        repeat (type_n + id_n + pay_n)
            record_bytes.push_back(8'($urandom));
    endtask

    task automatic build_message(input int tlv_len, input bit long_form, input int beyond);
        int pad_n;
        msg = {TAG_NDEF_MSG};
        if (long_form || tlv_len >= 255)
        begin
            msg.push_back(LEN_ESCAPE);
            msg.push_back(8'(tlv_len >> 8));
            msg.push_back(8'(tlv_len));
        end
        else
            msg.push_back(8'(tlv_len));
        foreach (record_bytes[i])
            msg.push_back(record_bytes[i]);
        pad_n = tlv_len - record_bytes.size();
        if (pad_n > 0)
            repeat (pad_n)
                msg.push_back(8'($urandom));
        repeat (beyond)
            msg.push_back(8'($urandom));
    endtask

    task automatic random_message();
        int          kind;
        int          type_n;
        int          id_n;
        int          pay_n;
        int          rec_len;
        int          tlv_len;
        int          cut;
        bit          sr;
        bit          il;
        logic [31:0] plen_val;
        kind = $urandom_range(99);
        if (kind < 14)
        begin
            msg = {};
            repeat ($urandom_range(1, 6))
                msg.push_back(8'($urandom));
            if ($urandom_range(1) == 1)
                msg[0] = TAG_NDEF_MSG;
            queue_message(-1);
            return;
        end
        sr = $urandom_range(1);
        il = $urandom_range(1);
        type_n = $urandom_range(0, 4);
        id_n = il ? $urandom_range(0, 3) : 0;
        pay_n = ($urandom_range(19) == 0) ? $urandom_range(250, 420) : $urandom_range(0, 12);
        if (pay_n > 255)
            sr = 1'b0;
        plen_val = 32'(pay_n);
        if (kind < 19)
        begin
            sr = 1'b0;
            plen_val = $urandom | 32'h0001_0000;
            pay_n = $urandom_range(0, 6);
        end
        build_record(sr, il, type_n, id_n, plen_val, pay_n);
        rec_len = record_bytes.size();
        tlv_len = rec_len + $urandom_range(0, 3);
        if (kind >= 19 && kind < 25)
            tlv_len = rec_len - $urandom_range(1, rec_len);
        build_message(tlv_len, $urandom_range(9) < 3, $urandom_range(0, 2));
        cut = (kind >= 25 && kind < 32) ? $urandom_range(0, msg.size() - 2) : -1;
        queue_message(cut);
    endtask

    task automatic wait_for_drain();
        while (items_accepted != items_queued || predicted_bytes.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        byte_in.valid = 1'b0;
        byte_in.data_byte = 8'd0;
        byte_in.end_of_data = 1'b0;
        byte_out.ready = 1'b0;
        byte_taken = 1'b0;
        tracker = STATE_RESET;
        items_queued = 0;
        items_accepted = 0;
        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 6;
        recv_stall_pct = 82;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A bad tag, an empty message, an all-empty record in the long form, a record
        // with type, id and payload, a truncated message and a TLV too short for its record.
        msg = {8'hFC, TAG_NDEF_MSG};
        queue_message(-1);
        msg = {TAG_NDEF_MSG, 8'h00, 8'hAA};
        queue_message(-1);
        msg = {TAG_NDEF_MSG, LEN_ESCAPE, 8'h00, 8'h03, HDR_SR_MASK, 8'h00, 8'h00};
        queue_message(-1);
        msg = {TAG_NDEF_MSG, 8'h07, HDR_SR_MASK | HDR_IL_MASK, 8'h01, 8'h01, 8'h01,
               8'h54, 8'h49, 8'hFF};
        queue_message(-1);
        msg = {TAG_NDEF_MSG, 8'h05, 8'hD1};
        queue_message(-1);
        msg = {TAG_NDEF_MSG, 8'h01, HDR_SR_MASK, 8'h00};
        queue_message(-1);
        wait_for_drain();

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 6 : (p == 1) ? 82 : 0;
            recv_stall_pct = (p == 0) ? 82 : (p == 1) ? 6 : 0;
            while (items_queued < 28 + (p + 1) * 434)
                random_message();
            wait_for_drain();
        end

        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("** ndef_record_stream_parser_core: PASSED **");
        else
            $display("** ndef_record_stream_parser_core: FAILED **");
        $finish;
    end

endmodule
